[hdl/file_url_percent_decoder_unit_defines.svh]
// ----------------------------------------------------------------------------
// File URL percent decoder assertion macros
// Concurrent check wrappers used by the decoder result sequencer.
// ----------------------------------------------------------------------------
`ifndef FILE_URL_PERCENT_DECODER_UNIT_DEFINES_SVH
`define FILE_URL_PERCENT_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define FUPD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("decoder check failed");
`define FUPD_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("decoder reset check failed");
`else
`define FUPD_ASSERT(lbl, prop)
`define FUPD_ASSERT_RST(lbl, prop)
`endif

`endif

[hdl/fupd_pkg.sv]
// ----------------------------------------------------------------------------
// File URL percent decoder package
// Prefix text, hex digit decoding, escape codes and the result job type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fupd_pkg;

  localparam int unsigned FullLen    = 16;
  localparam int unsigned ShortLen   = 7;
  localparam logic [7:0]  PercentChar = 8'h25;

  typedef enum logic [1:0] {
    EscNone    = 2'd0,
    EscPercent = 2'd1,
    EscDigit   = 2'd2
  } esc_t;

  typedef struct packed {
    logic [3:0]      pfx_idx;
    logic [3:0]      pfx_cnt;
    logic [2:0][7:0] tail;
    logic [1:0]      tail_cnt;
    logic            last;
  } job_t;

  function automatic logic [7:0] prefix_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = 8'h66;
      4'd1:    c = 8'h69;
      4'd2:    c = 8'h6c;
      4'd3:    c = 8'h65;
      4'd4:    c = 8'h3a;
      4'd5:    c = 8'h2f;
      4'd6:    c = 8'h2f;
      4'd7:    c = 8'h6c;
      4'd8:    c = 8'h6f;
      4'd9:    c = 8'h63;
      4'd10:   c = 8'h61;
      4'd11:   c = 8'h6c;
      4'd12:   c = 8'h68;
      4'd13:   c = 8'h6f;
      4'd14:   c = 8'h73;
      4'd15:   c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // Bit 4 flags a hex digit, bits 3:0 carry its value.
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    if (c inside {[8'h30:8'h39]}) begin
      r = {1'b1, c[3:0]};
    end else if (c inside {[8'h61:8'h66], [8'h41:8'h46]}) begin
      r = {1'b1, c[3:0] + 4'd9};
    end else begin
      r = 5'd0;
    end
    return r;
  endfunction

endpackage

[hdl/file_url_percent_decoder_unit.sv]
// ----------------------------------------------------------------------------
// File URL percent decoder unit
// Strips a file URL prefix and decodes percent escapes, one byte per word.
// ----------------------------------------------------------------------------
//  Channel | Direction | Handshake          | Payload
//  in_     | input     | in_valid/in_stall  | in_byte, in_end_of_string
//  out_    | output    | out_valid/out_stall| out_byte, out_has_byte, out_last
//
//  A word that yields at most one result is taken every cycle unless
//  out_stall holds it; a word that yields n results holds the input until
//  the result sequencer, one word per cycle, hands out its last result.
//  Results appear in the cycle after the input word is taken.
//  Reset is synchronous and active low; it returns to prefix matching.
//  While out_stall is high the pending result holds and the input stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module file_url_percent_decoder_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_end_of_string,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_has_byte,
  output logic       out_last
);

  fupd_pkg::job_t job;
  logic           job_valid;
  logic           free;
  logic           accept;

  assign in_stall = !free;
  assign accept   = in_valid && free;

  fupd_decode_core u_core (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept_i         (accept),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .job_o            (job),
    .job_valid_o      (job_valid)
  );

  fupd_result_seq u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .load_i       (accept),
    .load_job_i   (job),
    .load_valid_i (job_valid),
    .free_o       (free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_byte     (out_byte),
    .out_has_byte (out_has_byte),
    .out_last     (out_last)
  );

endmodule

[hdl/fupd_decode_core.sv]
// ----------------------------------------------------------------------------
// File URL percent decoder core
// Holds the prefix and escape state and turns one input word into a job.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fupd_decode_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept_i,
  input  logic [7:0]    in_byte,
  input  logic          in_end_of_string,
  output fupd_pkg::job_t job_o,
  output logic          job_valid_o
);

  logic               in_prefix_r, in_prefix_nxt;
  logic [4:0]         pos_r, pos_nxt;
  fupd_pkg::esc_t     esc_r, esc_nxt;
  logic [3:0]         high_r, high_nxt;
  logic [7:0]         raw_r, raw_nxt;

  always_comb begin
    logic       do_dec;
    logic       flush;
    logic [4:0] fpos;
    logic [4:0] hx;
    logic [1:0] tcnt;
    job_o         = '0;
    in_prefix_nxt = in_prefix_r;
    pos_nxt       = pos_r;
    esc_nxt       = esc_r;
    high_nxt      = high_r;
    raw_nxt       = raw_r;
    do_dec        = 1'b0;
    flush         = 1'b0;
    fpos          = pos_r;
    tcnt          = 2'd0;
    hx            = fupd_pkg::hex_decode(in_byte);

    if (in_prefix_r) begin
      if ((pos_r < 5'(fupd_pkg::FullLen)) &&
          (in_byte == fupd_pkg::prefix_char(pos_r[3:0]))) begin
        pos_nxt = pos_r + 5'd1;
        if (pos_nxt == 5'(fupd_pkg::FullLen)) begin
          in_prefix_nxt = 1'b0;
        end else if (in_end_of_string) begin
          flush         = 1'b1;
          fpos          = pos_nxt;
          in_prefix_nxt = 1'b0;
        end
      end else begin
        flush         = 1'b1;
        fpos          = pos_r;
        in_prefix_nxt = 1'b0;
        do_dec        = 1'b1;
      end
    end else begin
      do_dec = 1'b1;
    end

    if (flush) begin
      if (fpos >= 5'(fupd_pkg::ShortLen)) begin
        job_o.pfx_idx = 4'(fupd_pkg::ShortLen);
        job_o.pfx_cnt = 4'(fpos - 5'(fupd_pkg::ShortLen));
      end else begin
        job_o.pfx_idx = 4'd0;
        job_o.pfx_cnt = fpos[3:0];
      end
    end

    if (do_dec) begin
      case (esc_r)
        fupd_pkg::EscPercent: begin
          if (hx[4]) begin
            esc_nxt  = fupd_pkg::EscDigit;
            high_nxt = hx[3:0];
            raw_nxt  = in_byte;
          end else begin
            job_o.tail[tcnt] = fupd_pkg::PercentChar;
            tcnt             = tcnt + 2'd1;
            esc_nxt          = fupd_pkg::EscNone;
          end
        end
        fupd_pkg::EscDigit: begin
          if (hx[4]) begin
            job_o.tail[tcnt] = {high_r, hx[3:0]};
            tcnt             = tcnt + 2'd1;
            esc_nxt          = fupd_pkg::EscNone;
          end else begin
            job_o.tail[tcnt] = fupd_pkg::PercentChar;
            tcnt             = tcnt + 2'd1;
            job_o.tail[tcnt] = raw_r;
            tcnt             = tcnt + 2'd1;
            esc_nxt          = fupd_pkg::EscNone;
          end
        end
        default: begin
        end
      endcase
      // A byte that broke an escape is decoded again as a plain byte.
      if (esc_nxt == fupd_pkg::EscNone && !(esc_r == fupd_pkg::EscDigit && hx[4])) begin
        if (in_byte == fupd_pkg::PercentChar) begin
          esc_nxt = fupd_pkg::EscPercent;
        end else begin
          job_o.tail[tcnt] = in_byte;
          tcnt             = tcnt + 2'd1;
        end
      end
    end

    if (in_end_of_string) begin
      if (esc_nxt == fupd_pkg::EscPercent) begin
        job_o.tail[tcnt] = fupd_pkg::PercentChar;
        tcnt             = tcnt + 2'd1;
      end else if (esc_nxt == fupd_pkg::EscDigit) begin
        job_o.tail[tcnt] = fupd_pkg::PercentChar;
        tcnt             = tcnt + 2'd1;
        job_o.tail[tcnt] = raw_nxt;
        tcnt             = tcnt + 2'd1;
      end
      job_o.last    = 1'b1;
      in_prefix_nxt = 1'b1;
      pos_nxt       = 5'd0;
      esc_nxt       = fupd_pkg::EscNone;
      high_nxt      = 4'd0;
      raw_nxt       = 8'd0;
    end

    job_o.tail_cnt = tcnt;
    job_valid_o    = in_end_of_string || (job_o.pfx_cnt != 4'd0) || (tcnt != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_prefix_r <= 1'b1;
      pos_r       <= 5'd0;
      esc_r       <= fupd_pkg::EscNone;
      high_r      <= 4'd0;
      raw_r       <= 8'd0;
    end else if (accept_i) begin
      in_prefix_r <= in_prefix_nxt;
      pos_r       <= pos_nxt;
      esc_r       <= esc_nxt;
      high_r      <= high_nxt;
      raw_r       <= raw_nxt;
    end
  end

endmodule

[hdl/fupd_result_seq.sv]
// ----------------------------------------------------------------------------
// File URL percent decoder result sequencer
// Holds one job and hands its result words out one per unstalled cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "file_url_percent_decoder_unit_defines.svh"

module fupd_result_seq (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           load_i,
  input  fupd_pkg::job_t load_job_i,
  input  logic           load_valid_i,
  output logic           free_o,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte,
  output logic           out_has_byte,
  output logic           out_last
);

  logic           job_valid_r, job_valid_nxt;
  fupd_pkg::job_t job_r, job_nxt;
  logic           final_elem;
  logic           take;

  assign final_elem = ((job_r.pfx_cnt == 4'd0) && (job_r.tail_cnt <= 2'd1)) ||
                      ((job_r.pfx_cnt == 4'd1) && (job_r.tail_cnt == 2'd0));
  assign take       = job_valid_r && !out_stall;
  assign free_o     = !job_valid_r || (take && final_elem);

  assign out_valid = job_valid_r;
  assign out_last  = job_r.last && final_elem;

  always_comb begin
    if (job_r.pfx_cnt != 4'd0) begin
      out_byte     = fupd_pkg::prefix_char(job_r.pfx_idx);
      out_has_byte = 1'b1;
    end else if (job_r.tail_cnt != 2'd0) begin
      out_byte     = job_r.tail[0];
      out_has_byte = 1'b1;
    end else begin
      out_byte     = 8'd0;
      out_has_byte = 1'b0;
    end
  end

  always_comb begin
    job_valid_nxt = job_valid_r;
    job_nxt       = job_r;
    if (load_i) begin
      job_valid_nxt = load_valid_i;
      job_nxt       = load_job_i;
    end else if (take) begin
      if (final_elem) begin
        job_valid_nxt = 1'b0;
      end else if (job_r.pfx_cnt != 4'd0) begin
        job_nxt.pfx_cnt = job_r.pfx_cnt - 4'd1;
        job_nxt.pfx_idx = job_r.pfx_idx + 4'd1;
      end else begin
        job_nxt.tail[0]  = job_r.tail[1];
        job_nxt.tail[1]  = job_r.tail[2];
        job_nxt.tail_cnt = job_r.tail_cnt - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_valid_r <= 1'b0;
    end else begin
      job_valid_r <= job_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r <= job_nxt;
  end

  `FUPD_ASSERT(a_empty_is_last, out_valid && !out_has_byte |-> out_last)
  `FUPD_ASSERT(a_load_only_when_free, load_i && job_valid_r |-> take && final_elem)
  `FUPD_ASSERT(a_partial_take_keeps, take && !final_elem |=> job_valid_r)
  `FUPD_ASSERT_RST(a_reset_clears, !rst_n |=> !job_valid_r)

endmodule

[test/file_url_percent_decoder_unit_tb.sv]
// ----------------------------------------------------------------------------
// File URL percent decoder unit testbench
// Sends file URLs one byte per word. The URLs are directed corner cases,
// then random ones: well-formed URLs with full, short, cut-off or missing
// prefixes and valid or broken escapes, plus random byte noise. The
// testbench predicts every result word and compares each one, field by
// field, with the oldest prediction. Sender gaps and receiver stalls change
// from phase to phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module file_url_percent_decoder_unit_tb;

  localparam int           RandomWords   = 125;
  localparam int           PhaseWords    = 40;
  localparam int           QuietLimit    = 4000;
  localparam int           DrainCycles   = 10;
  localparam int           MaxPerWord    = 9;
  localparam logic [127:0] SchemeText    = "file://localhost";

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } url_word_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_data;
    logic       last;
  } path_result_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_end_of_string = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_has_byte;
  logic       out_last;

  url_word_t    url_feed_q[$];
  path_result_t decoded_q[$];

  logic           scan_prefix;
  logic [4:0]     matched_len;
  fupd_pkg::esc_t esc_state;
  logic [3:0]     esc_hi;
  logic [7:0]     esc_raw_byte;
  int             step_count;

  int words_in = 0;
  int results_out = 0;
  int urls_done = 0;
  int handshake_count = 0;
  int error_count = 0;
  bit run_done = 1'b0;

  file_url_percent_decoder_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_byte          (in_byte),
    .in_end_of_string (in_end_of_string),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_byte         (out_byte),
    .out_has_byte     (out_has_byte),
    .out_last         (out_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] scheme_char(input int idx);
    return SchemeText[8 * (15 - idx) +: 8];
  endfunction

  function automatic int hex_value(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
    return -1;
  endfunction

  function automatic void reset_decoder_state();
    scan_prefix  = 1'b1;
    matched_len  = '0;
    esc_state    = fupd_pkg::EscNone;
    esc_hi       = '0;
    esc_raw_byte = '0;
  endfunction

  function automatic void push_decoded(input logic [7:0] b);
    path_result_t r;
    r.data     = b;
    r.has_data = 1'b1;
    r.last     = 1'b0;
    if (step_count < MaxPerWord) begin
      decoded_q.push_back(r);
      step_count++;
    end
  endfunction

  function automatic void decode_path_byte(input logic [7:0] b);
    int v;
    bit again;
    again = 1'b1;
    while (again) begin
      again = 1'b0;
      if (esc_state == fupd_pkg::EscNone) begin
        if (b == fupd_pkg::PercentChar) esc_state = fupd_pkg::EscPercent;
        else push_decoded(b);
      end else begin
        v = hex_value(b);
        if (esc_state == fupd_pkg::EscPercent) begin
          if (v >= 0) begin
            esc_hi       = v[3:0];
            esc_raw_byte = b;
            esc_state    = fupd_pkg::EscDigit;
          end else begin
            push_decoded(fupd_pkg::PercentChar);
            esc_state = fupd_pkg::EscNone;
            again     = 1'b1;
          end
        end else if (v >= 0) begin
          push_decoded({esc_hi, v[3:0]});
          esc_state = fupd_pkg::EscNone;
        end else begin
          push_decoded(fupd_pkg::PercentChar);
          push_decoded(esc_raw_byte);
          esc_state = fupd_pkg::EscNone;
          again     = 1'b1;
        end
      end
    end
  endfunction

  function automatic void flush_held_prefix();
    int first;
    first = (matched_len >= fupd_pkg::ShortLen) ? int'(fupd_pkg::ShortLen) : 0;
    for (int i = first; i < matched_len; i++) begin
      push_decoded(scheme_char(i));
    end
    scan_prefix = 1'b0;
  endfunction

  function automatic void predict_word(input logic [7:0] b, input logic eos);
    path_result_t tail;
    step_count = 0;
    if (scan_prefix) begin
      if (matched_len < fupd_pkg::FullLen && b == scheme_char(matched_len)) begin
        matched_len++;
        if (matched_len >= fupd_pkg::FullLen) scan_prefix = 1'b0;
        else if (eos) flush_held_prefix();
      end else begin
        flush_held_prefix();
        decode_path_byte(b);
      end
    end else begin
      decode_path_byte(b);
    end
    if (eos) begin
      if (esc_state == fupd_pkg::EscPercent) begin
        push_decoded(fupd_pkg::PercentChar);
      end else if (esc_state == fupd_pkg::EscDigit) begin
        push_decoded(fupd_pkg::PercentChar);
        push_decoded(esc_raw_byte);
      end
      if (step_count == 0) begin
        tail = '{data: 8'h00, has_data: 1'b0, last: 1'b1};
      end else begin
        tail      = decoded_q.pop_back();
        tail.last = 1'b1;
      end
      decoded_q.push_back(tail);
      reset_decoder_state();
    end
  endfunction

  function automatic int sender_gap_pct();
    case ((words_in / PhaseWords) % 4)
      1:       return 50;
      3:       return 24;
      default: return 0;
    endcase
  endfunction

  function automatic int receiver_stall_pct();
    case ((words_in / PhaseWords) % 4)
      2:       return 50;
      3:       return 24;
      default: return 0;
    endcase
  endfunction

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $time, msg);
    error_count++;
  endtask

  task automatic push_word(input logic [7:0] b, input logic eos);
    url_word_t w;
    w.data = b;
    w.eos  = eos;
    url_feed_q.push_back(w);
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_word(s[i], i == s.len() - 1);
    end
  endtask

  function automatic logic [7:0] random_hex_char();
    int v;
    v = $urandom_range(0, 15);
    if (v < 10) return 8'h30 + v[7:0];
    return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + v[7:0] - 8'd10;
  endfunction

  function automatic logic [7:0] random_plain_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (c == fupd_pkg::PercentChar) c = 8'h2f;
    return c;
  endfunction

  function automatic logic [7:0] random_non_hex_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    if (hex_value(c) >= 0) c = 8'h7a;
    return c;
  endfunction

  task automatic add_random_url();
    int         start_size;
    int         len;
    logic [7:0] c;
    url_word_t  w;
    start_size = url_feed_q.size();
    if ($urandom_range(0, 9) <= 6) begin
      case ($urandom_range(0, 3))
        0: begin
          for (int i = 0; i < fupd_pkg::FullLen; i++) push_word(scheme_char(i), 1'b0);
        end
        1: begin
          for (int i = 0; i < fupd_pkg::ShortLen; i++) push_word(scheme_char(i), 1'b0);
        end
        2: begin
        end
        default: begin
          len = $urandom_range(1, fupd_pkg::FullLen - 1);
          for (int i = 0; i < len; i++) push_word(scheme_char(i), 1'b0);
          if ($urandom_range(0, 2) == 0) begin
            w     = url_feed_q.pop_back();
            w.eos = 1'b1;
            url_feed_q.push_back(w);
            return;
          end
          c = 8'($urandom_range(0, 255));
          if (c == scheme_char(len)) c = ~c;
          push_word(c, 1'b0);
        end
      endcase
      for (int s = $urandom_range(0, 6); s > 0; s--) begin
        case ($urandom_range(0, 5))
          0, 1, 2: begin
            push_word(random_plain_char(), 1'b0);
          end
          3, 4: begin
            push_word(fupd_pkg::PercentChar, 1'b0);
            push_word(random_hex_char(), 1'b0);
            push_word(random_hex_char(), 1'b0);
          end
          default: begin
            push_word(fupd_pkg::PercentChar, 1'b0);
            if ($urandom_range(0, 1)) push_word(random_hex_char(), 1'b0);
            if ($urandom_range(0, 2) != 0) push_word(random_non_hex_char(), 1'b0);
          end
        endcase
      end
    end else begin
      for (int i = $urandom_range(1, 10); i > 0; i--) begin
        case ($urandom_range(0, 2))
          0:       c = fupd_pkg::PercentChar;
          1:       c = random_hex_char();
          default: c = 8'($urandom_range(0, 255));
        endcase
        push_word(c, 1'b0);
      end
    end
    if (url_feed_q.size() == start_size) begin
      push_word(random_plain_char(), 1'b1);
    end else begin
      w     = url_feed_q.pop_back();
      w.eos = 1'b1;
      url_feed_q.push_back(w);
    end
  endtask

  always @(posedge clk) begin
    url_word_t next_word;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (url_feed_q.size() != 0 && $urandom_range(0, 99) >= sender_gap_pct()) begin
        next_word        = url_feed_q.pop_front();
        in_byte          <= next_word.data;
        in_end_of_string <= next_word.eos;
        in_valid         <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < receiver_stall_pct());
    end
  end

  always @(posedge clk) begin
    path_result_t want;
    if (!rst_n) begin
      reset_decoder_state();
    end else begin
      if (in_valid && !in_stall) begin
        predict_word(in_byte, in_end_of_string);
        words_in <= words_in + 1;
      end
      if (out_valid && !out_stall) begin
        results_out <= results_out + 1;
        if (out_last) urls_done <= urls_done + 1;
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result word: byte %02h has_byte %0b last %0b",
                                    out_byte, out_has_byte, out_last));
        end else begin
          want = decoded_q.pop_front();
          if (out_byte !== want.data) begin
            report_mismatch($sformatf("out_byte got %02h want %02h", out_byte, want.data));
          end
          if (out_has_byte !== want.has_data) begin
            report_mismatch($sformatf("out_has_byte got %0b want %0b",
                                      out_has_byte, want.has_data));
          end
          if (out_last !== want.last) begin
            report_mismatch($sformatf("out_last got %0b want %0b", out_last, want.last));
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        handshake_count <= handshake_count + 1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    int seen;
    quiet = 0;
    seen  = 0;
    while (!run_done && quiet < QuietLimit) begin
      @(posedge clk);
      if (handshake_count != seen) begin
        seen  = handshake_count;
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    if (!run_done) begin
      $display("[%0t] timeout: no word moved for %0d cycles", $time, QuietLimit);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    int directed_words;
    reset_decoder_state();
    add_text("%");
    add_text("fiX");
    add_text("file://");
    add_text("%aF");
    add_text("%4%41");
    push_word(8'h00, 1'b0);
    push_word(8'hff, 1'b1);
    add_text("%%");
    add_text("%g");
    directed_words = url_feed_q.size();
    while (url_feed_q.size() < directed_words + RandomWords) add_random_url();

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    while (url_feed_q.size() != 0 || in_valid) @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    run_done = 1'b1;

    $display("Decoded %0d URLs: %0d input words gave %0d result words, %0d mismatches.",
             urls_done, words_in, results_out, error_count);
    $display("Ran free-flowing, sender-gap, receiver-stall and mixed-pressure phases.");
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
